### rtl/core/whbh_pkg.sv
// Package for the word bitwise hash bucket block.
// Holds the field widths, register indexes, reset values and the divider state type.
// No dependencies.
`timescale 1ns / 1ps

package whbh_pkg;

  localparam int HASH_W      = 32;
  localparam int IDX_W       = 31;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HASH_W-1:0] SEED_RESET       = 32'd0;
  localparam logic [IDX_W-1:0]  TABLE_SIZE_RESET = 31'd65521;

  localparam int SHIFT_UP   = 5;
  localparam int SHIFT_DOWN = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 1'b1;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } mod_state_t;

endpackage

### rtl/core/whbh_front.sv
// Front end: accepts bytes, folds them into the running hash, queues finished words.
// Depends on whbh_pkg.
`timescale 1ns / 1ps

module whbh_front
  import whbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] char_byte,
  input  logic              last_byte,
  input  hash_t             seed,
  input  logic              queue_full,
  output logic              push,
  output idx_t              push_data
);

  logic  mid_word;
  hash_t running_hash;
  hash_t hash_base;
  hash_t char_ext;
  hash_t folded;
  logic  accept;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !in_stall;
  assign hash_base = mid_word ? running_hash : seed;
  assign char_ext  = {{(HASH_W-BYTE_W){char_byte[BYTE_W-1]}}, char_byte};
  assign folded    = hash_base ^ ((hash_base << SHIFT_UP) + char_ext
                                  + (hash_base >> SHIFT_DOWN));

  // Bit 31 is dropped on the way into the queue.
  assign push      = accept && last_byte;
  assign push_data = folded[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_word <= 1'b0;
    end else if (accept) begin
      mid_word <= !last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      running_hash <= folded;
    end
  end

endmodule

### rtl/core/whbh_fifo.sv
// Short register queue between the hash front end and the modulo back end.
// Depends on whbh_pkg.
`timescale 1ns / 1ps

module whbh_fifo
  import whbh_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  idx_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output idx_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  idx_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/whbh_mod.sv
// Back end: restoring remainder, one quotient bit per cycle, and the result register.
// Depends on whbh_pkg.
`timescale 1ns / 1ps

module whbh_mod
  import whbh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  idx_t table_size,
  input  logic queue_valid,
  input  idx_t queue_data,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output idx_t bucket
);

  localparam int CNT_W = $clog2(IDX_W);

  mod_state_t       state;
  mod_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  idx_t             rem;
  idx_t             dividend;
  logic [IDX_W:0]   trial;
  logic [IDX_W:0]   diff;
  logic             fits;
  idx_t             rem_step;
  logic             size_zero;

  assign size_zero = (table_size == '0);
  assign trial     = {rem, dividend[IDX_W-1]};
  assign diff      = trial - {1'b0, table_size};
  assign fits      = (trial >= {1'b0, table_size});
  assign rem_step  = fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (queue_valid) begin
          state_next = size_zero ? ST_OUT : ST_CALC;
        end
      end
      ST_CALC: begin
        if (cnt == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == ST_IDLE) && queue_valid;
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem      <= '0;
      dividend <= queue_data;
      cnt      <= CNT_W'(IDX_W - 1);
      if (size_zero) begin
        bucket <= queue_data;
      end
    end else if (state == ST_CALC) begin
      rem      <= rem_step;
      dividend <= {dividend[IDX_W-2:0], 1'b0};
      cnt      <= cnt - 1'b1;
      if (cnt == '0) begin
        bucket <= rem_step;
      end
    end
  end

endmodule

### rtl/core/word_bitwise_hash_bucket.sv
// Top level of the word bitwise hash bucket block.
// Depends on whbh_pkg, whbh_front, whbh_fifo and whbh_mod.
`timescale 1ns / 1ps

// Usage
// -----
// A word enters one byte per request on the input channel (char_byte, last_byte),
// taken when in_valid is high and in_stall is low. Each byte is folded into a
// 32-bit running hash in the cycle it is taken, so bytes of a word stream at one
// per cycle while not stalled. The first byte of a word starts from the seed register.
// A byte with last_byte set closes the word: its hash, with bit 31 dropped, is
// queued for the back end, and the next byte starts a new word from the seed.
// The back end reduces each queued hash modulo table_size with a restoring
// divider that produces one quotient bit per cycle. A word holds the back end while
// it picks the entry from the queue, runs 31 divider steps and waits in the output
// register, plus any time that out_stall holds it there. A table_size of zero
// skips the divider steps.
// The bucket is shown on the output channel until a cycle with out_stall low takes it.
// The back end takes the next queued hash only after the bucket of the last one
// has been taken.
// The input stalls only when the queue of finished words is full.
// Configuration writes (cfg_index 0 for seed, 1 for table_size) are always taken.
// Reset clears the queue, the divider and the word-in-progress flag and sets
// seed to 0 and table_size to 65521.

module word_bitwise_hash_bucket
  import whbh_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      char_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [IDX_W-1:0]       bucket,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  hash_t seed;
  idx_t  table_size;
  logic  queue_full;
  logic  push;
  idx_t  push_data;
  logic  pop;
  logic  queue_valid;
  idx_t  queue_data;

  // The register file never holds off a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= SEED_RESET;
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEED:       seed       <= cfg_data[HASH_W-1:0];
        CFG_TABLE_SIZE: table_size <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: byte intake and hash folding.
  whbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .last_byte  (last_byte),
    .seed       (seed),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue of finished word hashes.
  whbh_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .pop_data  (queue_data)
  );

  // Back end: modulo reduction and result register.
  whbh_mod u_mod (
    .clk         (clk),
    .rst         (rst),
    .table_size  (table_size),
    .queue_valid (queue_valid),
    .queue_data  (queue_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket      (bucket)
  );

endmodule
